@@ hdl/frd_pkg.sv @@
// Shared types and constants for the filament runout detector.
// No dependencies; imported by every module of the block.
package frd_pkg;

	localparam int FRD_COUNT_WIDTH = 16;
	localparam int FRD_TIME_WIDTH  = 32;

	localparam int MODE_W   = 2;
	localparam int WIN_W    = 16;
	localparam int DIST_W   = 20;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 2;
	localparam int POS_W    = 32;
	localparam int NOW_W    = 32;

	// detector modes (code 3 behaves as off)
	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LEVEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SMART = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE    = 2'd3;

	// reset values
	localparam logic [WIN_W-1:0]  WINDOW_RESET   = 16'd100;
	localparam logic [DIST_W-1:0] DISTANCE_RESET = 20'd7000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              invert_level;
		logic [WIN_W-1:0]  window_ms;
		logic [DIST_W-1:0] distance_um;
	} frd_cfg_t;

endpackage

@@ hdl/frd_filter.sv @@
// Windowed majority filter for the raw sensor pin.
// Depends on frd_pkg for the configuration struct.
module frd_filter #(
	parameter int COUNT_WIDTH = frd_pkg::FRD_COUNT_WIDTH,
	parameter int TIME_WIDTH  = frd_pkg::FRD_TIME_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [TIME_WIDTH-1:0] now,
	input  logic                  pin,
	input  frd_pkg::frd_cfg_t     cfg,
	output logic                  level_next
);
	import frd_pkg::*;

	logic                   level_q;
	logic [TIME_WIDTH-1:0]  wend_q;
	logic [COUNT_WIDTH-1:0] high_q;
	logic [COUNT_WIDTH-1:0] low_q;
	logic                   win_done;

	assign win_done   = now > wend_q;
	assign level_next = (en && win_done) ? (high_q > low_q) : level_q;

	// window bookkeeping; counts saturate at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			wend_q  <= '0;
			high_q  <= '0;
			low_q   <= '0;
		end else if (en) begin
			if (win_done) begin
				level_q <= high_q > low_q;
				wend_q  <= now + TIME_WIDTH'(cfg.window_ms);
				high_q  <= '0;
				low_q   <= '0;
			end else if (pin) begin
				if (high_q != '1) high_q <= high_q + 1'b1;
			end else begin
				if (low_q != '1) low_q <= low_q + 1'b1;
			end
		end
	end

endmodule

@@ hdl/frd_smart.sv @@
// Encoder-disc watchdog: runout when the extruder travels the set distance
// without a filtered level toggle. Depends on frd_pkg.
module frd_smart (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            level,
	input  logic signed [frd_pkg::POS_W-1:0] pos,
	input  frd_pkg::frd_cfg_t               cfg,
	output logic                            runout
);
	import frd_pkg::*;

	logic signed [POS_W-1:0] ref_q;
	logic                    last_q;
	logic                    alive_q;
	logic signed [POS_W:0]   diff;
	logic        [POS_W:0]   mag;
	logic                    reached;
	logic                    alive_n;

	// exact distance from the reference point, one bit wider than position
	assign diff    = {pos[POS_W-1], pos} - {ref_q[POS_W-1], ref_q};
	assign mag     = diff[POS_W] ? -diff : diff;
	assign reached = mag >= (POS_W + 1)'(cfg.distance_um);
	assign alive_n = alive_q | (last_q != level);
	assign runout  = en && reached && !alive_n;

	// alive always clears once the distance is reached
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q   <= '0;
			last_q  <= 1'b0;
			alive_q <= 1'b0;
		end else if (en) begin
			alive_q <= alive_n && !reached;
			if (reached) begin
				ref_q <= pos;
				if (alive_n) begin
					last_q <= level;
				end
			end
		end
	end

endmodule

@@ hdl/filament_runout_detector.sv @@
// Filament runout detector top level: config registers, input and result
// stages. Depends on frd_pkg, frd_filter and frd_smart.
//
// Usage:
//   Each input beat is one sensor poll (now_ms, raw_pin, extrude_pos_um,
//   printing, paused) and yields exactly one result beat (runout_detected,
//   filtered_pin, print_runout_flag), in order.
//   An input beat is taken when in_valid is high and in_stall low; a result
//   beat leaves when out_valid is high and out_stall low.
//   An input beat goes through the input register, then through the filter
//   and watchdog into the result register. Throughput is one poll per cycle
//   while out_stall is low, set by the combinational filter and distance
//   compare that close the state loop.
//   While out_stall is high the result holds and one more beat can wait in
//   the input register; after that in_stall rises.
//   The user writes registers through cfg_wr_en/cfg_index/cfg_wr_data only
//   while the block is idle (unchecked). Reset clears all detector state and
//   loads mode off, non-inverted, 100 ms window and 7000 um runout distance.
module filament_runout_detector #(
	parameter int COUNT_WIDTH = frd_pkg::FRD_COUNT_WIDTH,
	parameter int TIME_WIDTH  = frd_pkg::FRD_TIME_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [frd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [frd_pkg::CFG_W-1:0]          cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [frd_pkg::NOW_W-1:0]          now_ms,
	input  logic                               raw_pin,
	input  logic signed [frd_pkg::POS_W-1:0]   extrude_pos_um,
	input  logic                               printing,
	input  logic                               paused,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               runout_detected,
	output logic                               filtered_pin,
	output logic                               print_runout_flag
);
	import frd_pkg::*;

	frd_cfg_t cfg_q;

	logic                    valid_s1;
	logic [TIME_WIDTH-1:0]   now_s1;
	logic                    pin_s1;
	logic signed [POS_W-1:0] pos_s1;
	logic                    printing_s1;
	logic                    paused_s1;

	logic valid_s2;
	logic runout_s2;
	logic level_s2;
	logic print_s2;

	logic adv;
	logic step;
	logic filt_en;
	logic smart_en;
	logic level_next;
	logic smart_runout;
	logic runout;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= MODE_OFF;
			cfg_q.invert_level <= 1'b0;
			cfg_q.window_ms    <= WINDOW_RESET;
			cfg_q.distance_um  <= DISTANCE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DETECT_MODE: cfg_q.mode         <= cfg_wr_data[MODE_W-1:0];
				REG_INVERT:      cfg_q.invert_level <= cfg_wr_data[0];
				REG_WINDOW:      cfg_q.window_ms    <= cfg_wr_data[WIN_W-1:0];
				REG_DISTANCE:    cfg_q.distance_um  <= cfg_wr_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign step     = valid_s1 && adv;
	assign filt_en  = step && (cfg_q.mode == MODE_LEVEL || cfg_q.mode == MODE_SMART);
	assign smart_en = step && (cfg_q.mode == MODE_SMART);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			now_s1      <= now_ms[TIME_WIDTH-1:0];
			pin_s1      <= raw_pin;
			pos_s1      <= extrude_pos_um;
			printing_s1 <= printing;
			paused_s1   <= paused;
		end
	end

	frd_filter #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (filt_en),
		.now       (now_s1),
		.pin       (pin_s1),
		.cfg       (cfg_q),
		.level_next(level_next)
	);

	frd_smart u_smart (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (smart_en),
		.level (level_next),
		.pos   (pos_s1),
		.cfg   (cfg_q),
		.runout(smart_runout)
	);

	// runout decision per mode
	always_comb begin
		case (cfg_q.mode)
			MODE_LEVEL: runout = (level_next == cfg_q.invert_level);
			MODE_SMART: runout = smart_runout;
			default:    runout = 1'b0;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			runout_s2 <= runout;
			level_s2  <= level_next;
			print_s2  <= runout && printing_s1 && !paused_s1;
		end
	end

	assign out_valid         = valid_s2;
	assign runout_detected   = runout_s2;
	assign filtered_pin      = level_s2;
	assign print_runout_flag = print_s2;

endmodule

@@ sim/tb_filament_runout_detector.sv @@
// Self-checking testbench for filament_runout_detector: directed table and
// random poll sequences, each result compared with an in-bench predictor.
// Depends on frd_pkg and the filament_runout_detector RTL.
module tb_filament_runout_detector;
	import frd_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic runout;
		logic filt;
		logic flag;
	} poll_res_t;

	typedef struct {
		bit                is_cfg;
		logic [MODE_W-1:0] mode;
		logic              inv;
		logic [WIN_W-1:0]  win;
		logic [DIST_W-1:0] dist_um;
		logic [NOW_W-1:0]  t;
		logic              pin;
		logic [POS_W-1:0]  pos;
		logic              prt;
		logic              pau;
		bit                typed;
		poll_res_t         want;
	} dir_row_t;

	// block inputs, all known from time zero
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_wr_data = '0;
	logic                     in_valid = 1'b0;
	logic [NOW_W-1:0]         now_ms = '0;
	logic                     raw_pin = 1'b0;
	logic signed [POS_W-1:0]  extrude_pos_um = '0;
	logic                     printing = 1'b0;
	logic                     paused = 1'b0;
	logic                     out_stall = 1'b0;
	logic                     in_stall;
	logic                     out_valid;
	logic                     runout_detected;
	logic                     filtered_pin;
	logic                     print_runout_flag;

	// typed expectation that travels with the current poll beat
	bit                       poll_typed = 1'b0;
	poll_res_t                poll_want = '0;

	// predictor copy of configuration and detector state
	logic [MODE_W-1:0]        cfg_mode = MODE_OFF;
	logic                     cfg_invert = 1'b0;
	logic [WIN_W-1:0]         cfg_window = WINDOW_RESET;
	logic [DIST_W-1:0]        cfg_distance = DISTANCE_RESET;
	logic                     flt_level = 1'b0;
	logic [NOW_W-1:0]         win_end_ms = '0;
	logic [15:0]              high_cnt = '0;
	logic [15:0]              low_cnt = '0;
	logic [POS_W-1:0]         ref_pos_um = '0;
	logic                     seen_level = 1'b0;
	logic                     disc_alive = 1'b0;

	poll_res_t                expected_q[$];
	poll_res_t                mon_exp;
	poll_res_t                mon_got;
	int                       err_count = 0;
	int unsigned              cyc_count = 0;
	int                       idle_pct = 0;
	int                       stall_pct = 0;

	filament_runout_detector i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_ms(now_ms),
		.raw_pin(raw_pin),
		.extrude_pos_um(extrude_pos_um),
		.printing(printing),
		.paused(paused),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.runout_detected(runout_detected),
		.filtered_pin(filtered_pin),
		.print_runout_flag(print_runout_flag)
	);

	always #4 clk = ~clk;

	// one poll through the majority filter and the level / disc watchdog
	function automatic poll_res_t predict_runout(input logic [NOW_W-1:0] t, input logic pin,
			input logic [POS_W-1:0] pos, input logic prt, input logic pau);
		poll_res_t r;
		longint    travel;
		logic      hit;
		hit = 1'b0;
		if (cfg_mode == MODE_LEVEL || cfg_mode == MODE_SMART) begin
			if (t > win_end_ms) begin
				flt_level  = (high_cnt > low_cnt);
				win_end_ms = t + NOW_W'(cfg_window);
				high_cnt   = '0;
				low_cnt    = '0;
			end else if (pin) begin
				if (high_cnt != '1)
					high_cnt = high_cnt + 1'b1;
			end else begin
				if (low_cnt != '1)
					low_cnt = low_cnt + 1'b1;
			end
			if (cfg_mode == MODE_LEVEL) begin
				hit = (flt_level == cfg_invert);
			end else begin
				// exact distance, wider than the position so it never wraps
				travel = longint'($signed(pos)) - longint'($signed(ref_pos_um));
				if (travel < 0)
					travel = -travel;
				if (!disc_alive && seen_level != flt_level)
					disc_alive = 1'b1;
				if (travel >= longint'(cfg_distance)) begin
					ref_pos_um = pos;
					if (disc_alive) begin
						disc_alive = 1'b0;
						seen_level = flt_level;
					end else begin
						hit = 1'b1;
					end
				end
			end
		end
		r.runout = hit;
		r.filt   = flt_level;
		r.flag   = hit & prt & ~pau;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [MODE_W-1:0] mode, input logic inv,
			input logic [WIN_W-1:0] win, input logic [DIST_W-1:0] dist_um);
		dir_row_t row;
		row         = '{default: '0};
		row.is_cfg  = 1'b1;
		row.mode    = mode;
		row.inv     = inv;
		row.win     = win;
		row.dist_um = dist_um;
		return row;
	endfunction

	function automatic dir_row_t poll_row(input logic [NOW_W-1:0] t, input logic pin,
			input logic [POS_W-1:0] pos, input logic prt, input logic pau, input bit typed,
			input poll_res_t want);
		dir_row_t row;
		row       = '{default: '0};
		row.t     = t;
		row.pin   = pin;
		row.pos   = pos;
		row.prt   = prt;
		row.pau   = pau;
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	// present one poll beat, with random idle cycles ahead of it
	task automatic send_poll(input logic [NOW_W-1:0] t, input logic pin,
			input logic [POS_W-1:0] pos, input logic prt, input logic pau, input bit typed,
			input poll_res_t want);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		now_ms         <= t;
		raw_pin        <= pin;
		extrude_pos_um <= pos;
		printing       <= prt;
		paused         <= pau;
		poll_typed     <= typed;
		poll_want      <= want;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
	endtask

	// stop sending until every outstanding result has been seen
	task automatic wait_results_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all four registers while the block is idle
	task automatic set_config(input logic [MODE_W-1:0] mode, input logic inv,
			input logic [WIN_W-1:0] win, input logic [DIST_W-1:0] dist_um);
		wait_results_done();
		cfg_wr_en   <= 1'b1;
		cfg_index   <= REG_DETECT_MODE;
		cfg_wr_data <= CFG_W'(mode);
		@(posedge clk);
		cfg_index   <= REG_INVERT;
		cfg_wr_data <= CFG_W'(inv);
		@(posedge clk);
		cfg_index   <= REG_WINDOW;
		cfg_wr_data <= CFG_W'(win);
		@(posedge clk);
		cfg_index   <= REG_DISTANCE;
		cfg_wr_data <= CFG_W'(dist_um);
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		cfg_mode     = mode;
		cfg_invert   = inv;
		cfg_window   = win;
		cfg_distance = dist_um;
	endtask

	// receiver stall
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// run limit
	always @(posedge clk) begin
		cyc_count <= cyc_count + 1;
		if (cyc_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// predict on each accepted poll beat, check each accepted result beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				mon_exp = predict_runout(now_ms, raw_pin, extrude_pos_um, printing, paused);
				if (poll_typed)
					mon_exp = poll_want;
				expected_q.push_back(mon_exp);
			end
			if (out_valid && !out_stall) begin
				mon_got = {runout_detected, filtered_pin, print_runout_flag};
				if (expected_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("cycle %0d: result beat with nothing pending", cyc_count);
				end else begin
					mon_exp = expected_q.pop_front();
					if (mon_got.runout !== mon_exp.runout || mon_got.filt !== mon_exp.filt ||
							mon_got.flag !== mon_exp.flag) begin
						err_count++;
						if (err_count <= 10)
							$display("cycle %0d: expected %0b %0b %0b, got %0b %0b %0b",
								cyc_count, mon_exp.runout, mon_exp.filt, mon_exp.flag,
								mon_got.runout, mon_got.filt, mon_got.flag);
					end
				end
			end
		end
	end

	initial begin
		dir_row_t          tab[$];
		poll_res_t         none;
		int                idle_pat[4];
		int                stall_pat[4];
		int                n_items;
		logic [NOW_W-1:0]  t;
		logic [POS_W-1:0]  pos;
		logic [MODE_W-1:0] m;
		logic [WIN_W-1:0]  w;
		logic [DIST_W-1:0] d;
		logic              lvl;

		none      = '0;
		idle_pat  = '{0, 54, 0, 6};
		stall_pat = '{0, 0, 54, 6};

		// reset defaults: off mode, nothing reported
		tab.push_back(poll_row(32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, 3'b000));
		tab.push_back(poll_row(32'h0, 1'b0, 32'h8000_0000, 1'b1, 1'b1, 1'b1, 3'b000));
		// unused mode code behaves as off
		tab.push_back(cfg_row(MODE_SPARE, 1'b1, 16'd0, 20'd0));
		tab.push_back(poll_row(32'd5, 1'b1, 32'h0, 1'b1, 1'b0, 1'b1, 3'b000));
		// level mode, zero window, counts then a window close
		tab.push_back(cfg_row(MODE_LEVEL, 1'b0, 16'd0, 20'd0));
		tab.push_back(poll_row(32'd0, 1'b1, 32'h0, 1'b1, 1'b0, 1'b1, 3'b101));
		tab.push_back(poll_row(32'd0, 1'b1, 32'h0, 1'b1, 1'b1, 1'b1, 3'b100));
		tab.push_back(poll_row(32'd1, 1'b0, 32'h0, 1'b1, 1'b0, 1'b0, none));
		tab.push_back(poll_row(32'd1, 1'b0, 32'h0, 1'b1, 1'b0, 1'b0, none));
		tab.push_back(poll_row(32'd2, 1'b1, 32'h0, 1'b0, 1'b0, 1'b0, none));
		// inverted, widest window, window end wraps past zero
		tab.push_back(cfg_row(MODE_LEVEL, 1'b1, 16'hFFFF, 20'd1000000));
		tab.push_back(poll_row(32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, 1'b0, 1'b0, none));
		tab.push_back(poll_row(32'h10, 1'b1, 32'h0, 1'b1, 1'b0, 1'b0, none));
		tab.push_back(poll_row(32'hFFFE, 1'b1, 32'h0, 1'b1, 1'b0, 1'b0, none));
		tab.push_back(poll_row(32'hFFFF, 1'b0, 32'h0, 1'b1, 1'b0, 1'b0, none));
		// smart mode with zero distance: every poll hits the distance
		tab.push_back(cfg_row(MODE_SMART, 1'b0, 16'd0, 20'd0));
		tab.push_back(poll_row(32'h1_0000, 1'b0, 32'h0, 1'b1, 1'b0, 1'b0, none));
		tab.push_back(poll_row(32'h1_0000, 1'b1, 32'h0, 1'b1, 1'b0, 1'b0, none));
		tab.push_back(poll_row(32'h1_0001, 1'b0, 32'h0, 1'b1, 1'b0, 1'b0, none));
		tab.push_back(poll_row(32'h1_0001, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, none));
		// distance of 1000000 um, position extremes, exact threshold
		tab.push_back(cfg_row(MODE_SMART, 1'b0, 16'd10, 20'd1000000));
		tab.push_back(poll_row(32'h2_0000, 1'b1, 32'h8000_0000, 1'b1, 1'b0, 1'b0, none));
		tab.push_back(poll_row(32'h2_0001, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, none));
		tab.push_back(poll_row(32'h2_0002, 1'b0, 32'h7FFF_FFFF - 32'd1000000, 1'b1, 1'b0,
			1'b0, none));
		tab.push_back(poll_row(32'h2_0003, 1'b0, 32'h7FFF_FFFF - 32'd1, 1'b0, 1'b1, 1'b0,
			none));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < tab.size(); r++) begin
			if (tab[r].is_cfg)
				set_config(tab[r].mode, tab[r].inv, tab[r].win, tab[r].dist_um);
			else
				send_poll(tab[r].t, tab[r].pin, tab[r].pos, tab[r].prt, tab[r].pau,
					tab[r].typed, tab[r].want);
		end

		// random phases: mostly steady time and extrusion with a toggling sensor
		for (int p = 0; p < 7; p++) begin
			idle_pct  = idle_pat[p % 4];
			stall_pct = stall_pat[p % 4];
			if (p == 3)
				m = $urandom_range(1) ? MODE_OFF : MODE_SPARE;
			else if (p == 1 || p == 5)
				m = MODE_LEVEL;
			else
				m = MODE_SMART;
			w = (p == 0) ? 16'd0 : (p == 5) ? 16'hFFFF : 16'($urandom_range(20, 1));
			d = (p == 2) ? 20'd0 : (p == 4) ? 20'd1000000 : 20'($urandom_range(5000, 200));
			set_config(m, 1'($urandom_range(1)), w, d);
			n_items = (p == 3) ? 60 : 200;
			// start just past the current window so the filter keeps moving
			t = (win_end_ms >= 32'hFFFF_0000) ? 32'hFFFF_FFFF : win_end_ms + 32'd1;
			if (p == 1)
				t = 32'hFFFF_FFFF - 32'd700;
			pos = $urandom();
			lvl = 1'($urandom_range(1));
			for (int k = 0; k < n_items; k++) begin
				if (k == 100)
					wait_results_done();
				if ($urandom_range(99) < 15) begin
					send_poll(t - $urandom_range(3), 1'($urandom_range(1)), $urandom(),
						1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, none);
				end else begin
					t = t + $urandom_range(w / 3 + 1);
					if ($urandom_range(9) == 0)
						pos = pos - $urandom_range(d / 4 + 1);
					else
						pos = pos + $urandom_range(d / 4 + 1);
					if ($urandom_range(7) == 0)
						lvl = ~lvl;
					send_poll(t, ($urandom_range(9) == 0) ? ~lvl : lvl, pos,
						$urandom_range(9) != 0, $urandom_range(4) == 0, 1'b0, none);
				end
			end
		end

		wait_results_done();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
